/* hdl/tsd_pkg.sv */
// Shared types, codes and the transition function of the token scanner DFA.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package tsd_pkg;

    // Lexer state codes
    localparam logic [2:0] ST_START = 3'd0;
    localparam logic [2:0] ST_IDENT = 3'd1;
    localparam logic [2:0] ST_PLUS  = 3'd2;
    localparam logic [2:0] ST_MINUS = 3'd3;
    localparam logic [2:0] ST_INT   = 3'd4;
    localparam logic [2:0] ST_EXP   = 3'd5;
    localparam logic [2:0] ST_ESIGN = 3'd6;
    localparam logic [2:0] ST_REAL  = 3'd7;

    // Result kinds
    localparam logic [1:0] KIND_ACCEPT = 2'd0;
    localparam logic [1:0] KIND_TOKEN  = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;
    localparam logic [1:0] KIND_LINE   = 2'd3;

    // Token classes
    localparam logic [2:0] CLS_IDENT = 3'd0;
    localparam logic [2:0] CLS_PLUS  = 3'd1;
    localparam logic [2:0] CLS_MINUS = 3'd2;
    localparam logic [2:0] CLS_INT   = 3'd3;
    localparam logic [2:0] CLS_REAL  = 3'd4;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_E = 8'h65;
    localparam logic [7:0] CH_LOW_Z = 8'h7A;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] cls;
        logic [7:0] echo;
    } result_t;

    // One classified request: one or two results for the back end
    typedef struct packed {
        logic    two;
        result_t first;
        result_t second;
    } job_t;

    typedef struct packed {
        logic       ok;
        logic [2:0] nx;
    } step_t;

    // Queue status seen by the two ends
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= CH_LOW_A) && (c <= CH_LOW_Z);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_final(input logic [2:0] s);
        return (s == ST_IDENT) || (s == ST_PLUS) || (s == ST_MINUS) ||
               (s == ST_INT) || (s == ST_REAL);
    endfunction

    function automatic logic [2:0] class_of(input logic [2:0] s);
        logic [2:0] cls;
        unique case (s)
            ST_PLUS:  cls = CLS_PLUS;
            ST_MINUS: cls = CLS_MINUS;
            ST_INT:   cls = CLS_INT;
            ST_REAL:  cls = CLS_REAL;
            default:  cls = CLS_IDENT;
        endcase
        return cls;
    endfunction

    // Transition: ok is low when c cannot extend the token in state s
    function automatic step_t next_state(input logic [2:0] s, input logic [7:0] c);
        step_t r;
        r.ok = 1'b0;
        r.nx = ST_START;
        unique case (s)
            ST_START: begin
                if (is_letter(c)) begin
                    r.ok = 1'b1; r.nx = ST_IDENT;
                end else if (is_digit(c)) begin
                    r.ok = 1'b1; r.nx = ST_INT;
                end else if (c == CH_PLUS) begin
                    r.ok = 1'b1; r.nx = ST_PLUS;
                end else if (c == CH_MINUS) begin
                    r.ok = 1'b1; r.nx = ST_MINUS;
                end
            end
            ST_IDENT: begin
                if (is_letter(c) || is_digit(c)) begin
                    r.ok = 1'b1; r.nx = ST_IDENT;
                end
            end
            ST_INT: begin
                if (is_digit(c)) begin
                    r.ok = 1'b1; r.nx = ST_INT;
                end else if (c == CH_LOW_E) begin
                    r.ok = 1'b1; r.nx = ST_EXP;
                end
            end
            ST_EXP: begin
                if (is_digit(c)) begin
                    r.ok = 1'b1; r.nx = ST_REAL;
                end else if ((c == CH_PLUS) || (c == CH_MINUS)) begin
                    r.ok = 1'b1; r.nx = ST_ESIGN;
                end
            end
            ST_ESIGN, ST_REAL: begin
                if (is_digit(c)) begin
                    r.ok = 1'b1; r.nx = ST_REAL;
                end
            end
            default: begin
                r.ok = 1'b0;
            end
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* hdl/tsd_front.sv */
// Front end: takes characters, steps the lexer DFA and builds result jobs.
// Depends on tsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tsd_front
    import tsd_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_char_in,
    input  wire q_status_t  q_status,
    output logic            push,
    output job_t            push_job
);

    logic [2:0] lexer_state_reg;
    logic [2:0] lexer_state_next;
    step_t      step_cur;
    step_t      step_start;
    result_t    tail;

    assign s_ready = !q_status.full;
    assign push    = s_valid && s_ready;

    always_comb begin
        step_cur   = next_state(lexer_state_reg, s_char_in);
        step_start = next_state(ST_START, s_char_in);

        // result of rescanning from the start state
        tail.kind = step_start.ok ? KIND_ACCEPT : KIND_ERROR;
        tail.cls  = CLS_IDENT;
        tail.echo = step_start.ok ? s_char_in : 8'd0;

        push_job.two          = 1'b0;
        push_job.first        = '0;
        push_job.second       = '0;
        lexer_state_next      = lexer_state_reg;

        priority if ((s_char_in == CH_LF) || (s_char_in == CH_NUL)) begin
            push_job.first.kind = KIND_LINE;
            lexer_state_next    = ST_START;
        end else if (step_cur.ok) begin
            push_job.first.kind = KIND_ACCEPT;
            push_job.first.echo = s_char_in;
            lexer_state_next    = step_cur.nx;
        end else begin
            lexer_state_next = step_start.ok ? step_start.nx : ST_START;
            if (lexer_state_reg != ST_START) begin
                push_job.two = 1'b1;
                if (is_final(lexer_state_reg)) begin
                    push_job.first.kind = KIND_TOKEN;
                    push_job.first.cls  = class_of(lexer_state_reg);
                end else begin
                    push_job.first.kind = KIND_ERROR;
                end
                push_job.second = tail;
            end else begin
                push_job.first = tail;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lexer_state_reg <= ST_START;
        end else if (push) begin
            lexer_state_reg <= lexer_state_next;
        end
    end

`ifndef SYNTHESIS
    a_line_end_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && ((s_char_in == CH_LF) || (s_char_in == CH_NUL)))
        |=> (lexer_state_reg == ST_START))
        else $error("line end did not return lexer to start");

    a_two_only_midtoken: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && push_job.two) |-> (lexer_state_reg != ST_START))
        else $error("two-result job built from the start state");

    a_hold_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !push |=> $stable(lexer_state_reg))
        else $error("lexer state moved without an accepted request");
`endif

endmodule

`default_nettype wire

/* hdl/tsd_queue.sv */
// Short job queue between the front and back ends of the token scanner.
// Depends on tsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tsd_queue
    import tsd_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      push,
    input  wire job_t      push_job,
    input  wire logic      pop,
    output job_t           head_job,
    output q_status_t      q_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign q_status.full  = (count_reg == FULL_CNT);
    assign q_status.empty = (count_reg == '0);
    assign do_push        = push && !q_status.full;
    assign do_pop         = pop && !q_status.empty;
    assign head_job       = slot_reg[rptr_reg];

    always_comb begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_push) begin
            wptr_next = (wptr_reg == LAST_PTR) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop) begin
            rptr_next = (rptr_reg == LAST_PTR) ? '0 : rptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wptr_reg] <= push_job;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_CNT)
        else $error("queue count beyond depth");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_status.full)
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_status.empty)
        else $error("pop from an empty queue");
`endif

endmodule

`default_nettype wire

/* hdl/tsd_back.sv */
// Back end: drains jobs from the queue and drives one result per cycle, while
// m_ready allows, through a registered output stage. Depends on tsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tsd_back
    import tsd_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire q_status_t  q_status,
    input  wire job_t       head_job,
    output logic            pop,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [1:0]      m_result_kind,
    output logic [2:0]      m_token_class,
    output logic [7:0]      m_echo_char,
    output logic            m_last_of_run
);

    logic    out_valid_reg, out_valid_next;
    result_t out_res_reg, out_res_next;
    logic    out_last_reg, out_last_next;
    logic    sec_valid_reg, sec_valid_next;
    result_t sec_res_reg, sec_res_next;
    logic    out_free;

    assign out_free = !out_valid_reg || m_ready;
    assign pop      = out_free && !sec_valid_reg && !q_status.empty;

    always_comb begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        out_last_next  = out_last_reg;
        sec_valid_next = sec_valid_reg;
        sec_res_next   = sec_res_reg;
        if (out_free) begin
            if (sec_valid_reg) begin
                out_valid_next = 1'b1;
                out_res_next   = sec_res_reg;
                out_last_next  = 1'b1;
                sec_valid_next = 1'b0;
            end else if (!q_status.empty) begin
                out_valid_next = 1'b1;
                out_res_next   = head_job.first;
                out_last_next  = !head_job.two;
                sec_valid_next = head_job.two;
                sec_res_next   = head_job.second;
            end else begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            sec_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            sec_valid_reg <= sec_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_res_reg  <= out_res_next;
        out_last_reg <= out_last_next;
        sec_res_reg  <= sec_res_next;
    end

    assign m_valid       = out_valid_reg;
    assign m_result_kind = out_res_reg.kind;
    assign m_token_class = out_res_reg.cls;
    assign m_echo_char   = out_res_reg.echo;
    assign m_last_of_run = out_last_reg;

`ifndef SYNTHESIS
    a_second_behind_first: assert property (@(posedge aclk) disable iff (!aresetn)
        sec_valid_reg |-> (out_valid_reg && !out_last_reg))
        else $error("pending second result without its first on the output");

    a_first_of_pair_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_last_reg)
        |-> ((out_res_reg.kind == KIND_TOKEN) || (out_res_reg.kind == KIND_ERROR)))
        else $error("first of a result pair is not a token end or error");

    a_pair_completes: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && m_ready && !out_last_reg) |=> (out_valid_reg && out_last_reg))
        else $error("second result of a pair did not follow");
`endif

endmodule

`default_nettype wire

/* hdl/token_scanner_dfa_top.sv */
// A character accepted by the front is written into the queue, then moved into the
// back end's output register, from where its first result shows.
// Throughput: one character per cycle when each gives one result and m_ready is
// high; a character that closes a token gives two results, which the single
// result port sends in turn. The queue (QUEUE_DEPTH jobs) absorbs short bursts.
// Reset: aresetn is synchronous, active low; lexer returns to start, queue empties.
// Top level of the token scanner DFA. Instantiates tsd_front, tsd_queue, tsd_back.
`timescale 1ns / 1ps
`default_nettype none

module token_scanner_dfa_top
    import tsd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // character request channel
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_char_in,
    // result request channel
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [1:0]      m_result_kind,
    output logic [2:0]      m_token_class,
    output logic [7:0]      m_echo_char,
    output logic            m_last_of_run
);

    // Front end steps the DFA on every accepted character and packs the one or
    // two results it causes into a job. The back end replays a job as one or
    // two results. The queue lets the front keep taking characters while the
    // back is busy with a two-result job or stalled by m_ready.
    q_status_t q_status;
    logic      push;
    job_t      push_job;
    logic      pop;
    job_t      head_job;

    tsd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_char_in (s_char_in),
        .q_status  (q_status),
        .push      (push),
        .push_job  (push_job)
    );

    tsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .q_status (q_status)
    );

    // Output register lives in the back end, so a waiting result stalls the
    // front only once the queue behind it is full.
    tsd_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_status      (q_status),
        .head_job      (head_job),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_kind (m_result_kind),
        .m_token_class (m_token_class),
        .m_echo_char   (m_echo_char),
        .m_last_of_run (m_last_of_run)
    );

endmodule

`default_nettype wire

/* tb/tb_token_scanner_dfa_top.sv */
// Self-checking testbench for token_scanner_dfa_top: directed and random character streams.
// Carries its own lexer prediction and checks every result request in order.
// Depends on tsd_pkg (hdl/tsd_pkg.sv) and the RTL under hdl/.
`timescale 1ns / 1ps

module tb_token_scanner_dfa_top;
    import tsd_pkg::*;

    localparam int RANDOM_CHARS = 600;
    localparam int STALL_LIMIT  = 4000;   // cycles with no request moving on either side
    localparam int DRAIN_CYCLES = 8;      // well past the first-result latency
    localparam int REPORT_MAX   = 10;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [2:0] NO_CLASS = 3'd0;
    localparam logic [7:0] NO_ECHO  = 8'h00;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] cls;
        logic [7:0] echo;
        logic       last;
    } scan_result_t;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic [7:0] s_char_in = 8'h00;
    logic       m_ready   = 1'b0;
    logic       s_ready;
    logic       m_valid;
    logic [1:0] m_result_kind;
    logic [2:0] m_token_class;
    logic [7:0] m_echo_char;
    logic       m_last_of_run;

    // Characters waiting to be sent; the front is what the driver presents.
    logic [7:0]   char_queue[$];
    // Results the lexer should produce, oldest first.
    scan_result_t expected_results[$];
    logic [2:0]   scan_state = ST_START;

    int chars_taken    = 0;
    int char_total     = 0;
    int mismatch_count = 0;
    int stall_cycles   = 0;
    bit char_hs        = 1'b0;
    scan_result_t got_result, want_result;

    token_scanner_dfa_top uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_char_in     (s_char_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_kind (m_result_kind),
        .m_token_class (m_token_class),
        .m_echo_char   (m_echo_char),
        .m_last_of_run (m_last_of_run)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Lexer prediction
    // ------------------------------------------------------------------

    // Returns 1 and the next state when c can grow the token held in state s.
    function automatic bit extends_token(input logic [2:0] s, input logic [7:0] c,
                                         output logic [2:0] nx);
        bit ok;
        bit letter;
        bit digit;
        ok     = 1'b1;
        letter = (c >= CH_LOW_A) && (c <= CH_LOW_Z);
        digit  = (c >= CH_ZERO) && (c <= CH_NINE);
        nx     = ST_START;
        case (s)
            ST_START: begin
                if (letter) nx = ST_IDENT;
                else if (digit) nx = ST_INT;
                else if (c == CH_PLUS) nx = ST_PLUS;
                else if (c == CH_MINUS) nx = ST_MINUS;
                else ok = 1'b0;
            end
            ST_IDENT: begin
                if (letter || digit) nx = ST_IDENT;
                else ok = 1'b0;
            end
            ST_INT: begin
                if (digit) nx = ST_INT;
                else if (c == CH_LOW_E) nx = ST_EXP;
                else ok = 1'b0;
            end
            ST_EXP: begin
                if (digit) nx = ST_REAL;
                else if ((c == CH_PLUS) || (c == CH_MINUS)) nx = ST_ESIGN;
                else ok = 1'b0;
            end
            ST_ESIGN, ST_REAL: begin
                if (digit) nx = ST_REAL;
                else ok = 1'b0;
            end
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

    function automatic void push_result(input logic [1:0] kind, input logic [2:0] cls,
                                        input logic [7:0] echo);
        expected_results.push_back('{kind, cls, echo, 1'b0});
    endfunction

    // Advance the lexer by one character and queue the results it gives.
    function automatic void scan_char(input logic [7:0] c);
        logic [2:0] nx;
        if ((c == CH_LF) || (c == CH_NUL)) begin
            // line end drops any token in progress
            push_result(KIND_LINE, NO_CLASS, NO_ECHO);
            scan_state = ST_START;
        end else if (extends_token(scan_state, c, nx)) begin
            push_result(KIND_ACCEPT, NO_CLASS, c);
            scan_state = nx;
        end else begin
            // close what we have: token end on a final state, error otherwise
            case (scan_state)
                ST_START: ;
                ST_IDENT: push_result(KIND_TOKEN, CLS_IDENT, NO_ECHO);
                ST_PLUS:  push_result(KIND_TOKEN, CLS_PLUS, NO_ECHO);
                ST_MINUS: push_result(KIND_TOKEN, CLS_MINUS, NO_ECHO);
                ST_INT:   push_result(KIND_TOKEN, CLS_INT, NO_ECHO);
                ST_REAL:  push_result(KIND_TOKEN, CLS_REAL, NO_ECHO);
                default:  push_result(KIND_ERROR, NO_CLASS, NO_ECHO);
            endcase
            // same character again from the start state; a bad start is dropped
            if (extends_token(ST_START, c, nx)) begin
                push_result(KIND_ACCEPT, NO_CLASS, c);
                scan_state = nx;
            end else begin
                push_result(KIND_ERROR, NO_CLASS, NO_ECHO);
                scan_state = ST_START;
            end
        end
        expected_results[expected_results.size() - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic add_char(input logic [7:0] c);
        char_queue.push_back(c);
    endtask

    task automatic add_text(input string txt);
        for (int i = 0; i < txt.len(); i++) char_queue.push_back(txt[i]);
    endtask

    function automatic logic [7:0] rand_letter();
        return CH_LOW_A + 8'($urandom_range(25));
    endfunction

    function automatic logic [7:0] rand_digit();
        return CH_ZERO + 8'($urandom_range(9));
    endfunction

    function automatic logic [7:0] rand_sign();
        return $urandom_range(1) ? CH_PLUS : CH_MINUS;
    endfunction

    task automatic add_digits(input int n);
        repeat (n) add_char(rand_digit());
    endtask

    // Idle rates per third of the run: sender 31 / receiver 50, then swapped,
    // then no idling at all.
    function automatic int idle_pct(input bit sender);
        if (chars_taken < char_total / 3) return sender ? 31 : 50;
        if (chars_taken < (2 * char_total) / 3) return sender ? 50 : 31;
        return 0;
    endfunction

    // ------------------------------------------------------------------
    // Driver and receiver: everything changes on the falling edge
    // ------------------------------------------------------------------

    // A request stays up with its character until char_hs says it was taken.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || char_hs) begin
            if ((char_queue.size() > 0) && ($urandom_range(99) >= idle_pct(1'b1))) begin
                s_valid   <= 1'b1;
                s_char_in <= char_queue[0];
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= idle_pct(1'b0));
    end

    // ------------------------------------------------------------------
    // Monitor: samples at the rising edge, before the block updates
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        // character side: predict as soon as the request is taken
        char_hs = aresetn && s_valid && s_ready;
        if (char_hs) begin
            scan_char(s_char_in);
            void'(char_queue.pop_front());
            chars_taken++;
        end

        // result side: compare against the oldest prediction
        if (aresetn && m_valid && m_ready) begin
            got_result = '{m_result_kind, m_token_class, m_echo_char, m_last_of_run};
            if (expected_results.size() == 0) begin
                if (mismatch_count < REPORT_MAX)
                    $display("unexpected result: kind %0d class %0d echo %02h last %0d",
                             got_result.kind, got_result.cls, got_result.echo,
                             got_result.last);
                mismatch_count++;
            end else begin
                want_result = expected_results.pop_front();
                if (got_result !== want_result) begin
                    if (mismatch_count < REPORT_MAX) begin
                        $display("mismatch: expected kind %0d class %0d echo %02h last %0d",
                                 want_result.kind, want_result.cls, want_result.echo,
                                 want_result.last);
                        $display("          got kind %0d class %0d echo %02h last %0d",
                                 got_result.kind, got_result.cls, got_result.echo,
                                 got_result.last);
                    end
                    mismatch_count++;
                end
            end
        end

        // watchdog: nothing moving on either channel for too long means a hang
        if (char_hs || (m_valid && m_ready)) stall_cycles = 0;
        else stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        int target;
        int pick;

        // Directed: NUL line end; identifier through 'z' and '9'; back-to-back
        // signs; sign then digit; break right after 'e' on a capital (error,
        // then bad start); line end inside a real; complete real closed by a
        // blank (token end, then bad start); all-ones code; break after the
        // exponent sign with a letter that restarts as identifier.
        add_char(CH_NUL);
        add_text("az9++-09eZ1e-");
        add_char(CH_LF);
        add_text("5e+7 ");
        add_char(8'hFF);
        add_text("3e+x");
        add_char(CH_LF);

        // Random: mostly well-formed tokens, often glued together so that one
        // character both closes a token and starts the next; the rest is noise.
        target = char_queue.size() + RANDOM_CHARS;
        while (char_queue.size() < target) begin
            pick = $urandom_range(99);
            if (pick < 25) begin
                add_char(rand_letter());
                repeat ($urandom_range(5))
                    add_char($urandom_range(1) ? rand_letter() : rand_digit());
            end else if (pick < 45) begin
                add_digits($urandom_range(1, 4));
            end else if (pick < 60) begin
                add_digits($urandom_range(1, 3));
                add_char(CH_LOW_E);
                if ($urandom_range(1)) add_char(rand_sign());
                add_digits($urandom_range(1, 3));
            end else if (pick < 70) begin
                add_char(rand_sign());
            end else if (pick < 78) begin
                // real cut short after 'e' or after its sign
                add_digits($urandom_range(1, 2));
                add_char(CH_LOW_E);
                if ($urandom_range(1)) add_char(rand_sign());
            end else begin
                add_char(8'($urandom_range(255)));
            end

            pick = $urandom_range(99);
            if (pick < 40) begin
                // no separator
            end else if (pick < 70) begin
                add_char(CH_SPACE);
            end else if (pick < 85) begin
                add_char($urandom_range(1) ? CH_LF : CH_NUL);
            end else begin
                add_char(8'($urandom_range(255)));
            end
        end
        char_total = char_queue.size();

        // reset held low from the start, released on a falling edge
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        while ((char_queue.size() != 0) || (expected_results.size() != 0))
            @(posedge aclk);
        // catch any stray result after the last expected one
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
